### sv/strict_table_interp_rate_unit_assert.svh
// Assertion macros shared by the rate table interpolation block.
`ifndef STRICT_TABLE_INTERP_RATE_UNIT_ASSERT_SVH
`define STRICT_TABLE_INTERP_RATE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STIR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define STIR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STIR_ASSERT_IMP(label, ante, cons, msg)
`define STIR_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### sv/stir_pkg.sv
// Shared types and constants of the rate table interpolation block.
`timescale 1ns / 1ps
package stir_pkg;

  // One table breakpoint: energy and rate, both Q16.16 signed
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } entry_t;

  localparam int LIMBS     = 5;
  localparam int PROD_W    = 32 * LIMBS;
  localparam int DIV_NUM_W = 65;

  // 1/N_A scaled by 2^112
  localparam logic [63:0] INV_NA   = 64'd8622011782;
  localparam logic [62:0] PROG_MAX = {63{1'b1}};

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic REG_NUM_POINTS   = 1'b0;
  localparam logic REG_OUTPUT_SHIFT = 1'b1;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_RANGE     = 3'd1;
  localparam logic [2:0] STAT_NEG_DENS  = 3'd2;
  localparam logic [2:0] STAT_NEG_CONC  = 3'd3;
  localparam logic [2:0] STAT_NEG_RATE  = 3'd4;

endpackage

### sv/strict_table_interp_rate_unit.sv
// A sign error goes straight to the result. Otherwise the rotating table scan runs,
// then, as the query needs, the serial divider and three limb-serial multiplies.
// One item in flight; a load item writes its table cell and gives no result.
// Reset (rst_n, synchronous) clears control and config; the table is not cleared.
`timescale 1ns / 1ps
module strict_table_interp_rate_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_index, point_energy, point_rate, query_energy, electron_density, target_conc
  input  logic [183:0] in_tdata,
  // kind
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // progress
  output logic [63:0]  out_tdata,
  // status
  output logic [2:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [6:0]   cfg_wdata
);

`include "strict_table_interp_rate_unit_assert.svh"

  localparam int KW = $clog2(TABLE_DEPTH);
  localparam int NW = (KW + 1 > 7) ? KW + 1 : 7;
  localparam int PW = stir_pkg::PROD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_EVAL, S_DIV, S_CHECK, S_PROD, S_SHIFT, S_DONE
  } state_t;

  state_t state_r;

  // Input fields
  logic [5:0]         in_idx;
  logic signed [31:0] in_pe;
  logic signed [31:0] in_pr;
  logic signed [31:0] in_me;
  logic [47:0]        in_dens;
  logic [31:0]        in_conc;
  logic               in_acc;
  logic               out_acc;
  logic               load_go;
  logic               rot_en;

  assign in_idx  = in_tdata[5:0];
  assign in_pe   = in_tdata[37:6];
  assign in_pr   = in_tdata[69:38];
  assign in_me   = in_tdata[101:70];
  assign in_dens = in_tdata[149:102];
  assign in_conc = in_tdata[181:150];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_go   = in_acc && (in_tuser[0] == stir_pkg::KIND_LOAD);
  assign rot_en    = (state_r == S_SCAN);

  // Config registers
  logic [6:0]    np_r;
  logic [5:0]    osh_r;
  logic [NW-1:0] np_x;
  logic [NW-1:0] n_eff;

  // Clamp the breakpoint count to the table
  always_comb begin
    np_x = NW'(np_r);
    if (np_x < NW'(2)) begin
      n_eff = NW'(2);
    end else if (np_x > NW'(TABLE_DEPTH)) begin
      n_eff = NW'(TABLE_DEPTH);
    end else begin
      n_eff = np_x;
    end
  end

  // Table as a ring of cells rotating toward cell 0
  stir_pkg::entry_t cell_q [TABLE_DEPTH];
  stir_pkg::entry_t load_ent;

  assign load_ent = '{x: in_pe, y: in_pr};

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    stir_cell u_cell (
      .clk      (clk),
      .wr_en    (load_go && ({26'd0, in_idx} == 32'(g))),
      .wr_d     (load_ent),
      .shift_en (rot_en),
      .nb_d     (cell_q[(g + 1) % TABLE_DEPTH]),
      .q        (cell_q[g])
    );
  end

  // Working registers
  logic [KW-1:0]      k_r;
  logic signed [31:0] e_r;
  logic [47:0]        dens_r;
  logic [31:0]        conc_r;
  logic signed [31:0] xf_r, yf_r, xl_r, yl_r;
  logic               found_r;
  logic signed [31:0] bx0_r, by0_r, bx1_r, by1_r;
  logic               neg_r;
  logic [31:0]        den_r;
  logic [64:0]        num_r;
  logic [31:0]        rate_r;
  logic [2:0]         stat_r;
  logic [PW-1:0]      acc_r;
  logic [1:0]         mi_r;
  logic               div_go_r;
  logic               mul_go_r;
  logic [62:0]        prog_r;
  logic               out_valid_r;
  logic [62:0]        out_data_r;
  logic [2:0]         out_stat_r;

  // Interpolation terms
  logic [NW-1:0] kx;
  logic [31:0]   de, dx;
  logic [32:0]   dy, mag;
  logic          div_done;
  logic [64:0]   div_q;
  logic          mul_done;
  logic [PW-1:0] mul_p;
  logic [63:0]   mul_m;
  logic [PW-1:0] shifted;

  assign kx  = NW'(k_r);
  assign de  = 32'(e_r - bx0_r);
  assign dx  = 32'(bx1_r - bx0_r);
  assign dy  = {by1_r[31], by1_r} - {by0_r[31], by0_r};
  assign mag = dy[32] ? (33'd0 - dy) : dy;

  // Pick the multiplier operand for each pass
  always_comb begin
    unique case (mi_r)
      2'd0:    mul_m = {32'd0, conc_r};
      2'd1:    mul_m = stir_pkg::INV_NA;
      default: mul_m = {16'd0, dens_r};
    endcase
  end

  assign shifted = acc_r >> (7'd64 + {1'b0, osh_r});

  stir_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_q)
  );

  stir_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (acc_r),
    .m     (mul_m),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign out_acc = out_valid_r && out_tready;

  // Sequencer, config and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      found_r     <= 1'b0;
      mi_r        <= '0;
      div_go_r    <= 1'b0;
      mul_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      np_r        <= 7'd2;
      osh_r       <= '0;
    end else begin
      div_go_r <= 1'b0;
      mul_go_r <= 1'b0;
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr[0])
          stir_pkg::REG_NUM_POINTS:   np_r  <= cfg_wdata;
          stir_pkg::REG_OUTPUT_SHIFT: osh_r <= cfg_wdata[5:0];
          default:                    np_r  <= np_r;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser[0] == stir_pkg::KIND_EVAL)) begin
            e_r     <= in_me;
            dens_r  <= in_dens;
            conc_r  <= in_conc;
            found_r <= 1'b0;
            k_r     <= '0;
            // Sign checks come before the lookup
            priority if (in_dens[47]) begin
              stat_r  <= stir_pkg::STAT_NEG_DENS;
              state_r <= S_DONE;
            end else if (in_conc[31]) begin
              stat_r  <= stir_pkg::STAT_NEG_CONC;
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Cell 0 shows entry k, cell 1 entry k+1
          if (k_r == '0) begin
            xf_r <= cell_q[0].x;
            yf_r <= cell_q[0].y;
          end
          if (kx == n_eff - NW'(1)) begin
            xl_r <= cell_q[0].x;
            yl_r <= cell_q[0].y;
          end
          if (!found_r && (kx + NW'(1) < n_eff) && (cell_q[0].x <= e_r) &&
              (e_r < cell_q[1].x)) begin
            found_r <= 1'b1;
            bx0_r   <= cell_q[0].x;
            by0_r   <= cell_q[0].y;
            bx1_r   <= cell_q[1].x;
            by1_r   <= cell_q[1].y;
          end
          // A full turn brings the ring home
          if (k_r == KW'(TABLE_DEPTH - 1)) begin
            k_r     <= '0;
            state_r <= S_EVAL;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_EVAL: begin
          priority if ((e_r < xf_r) || (e_r > xl_r)) begin
            stat_r  <= stir_pkg::STAT_RANGE;
            state_r <= S_DONE;
          end else if (e_r == xf_r) begin
            rate_r  <= yf_r;
            state_r <= S_CHECK;
          end else if (e_r == xl_r) begin
            rate_r  <= yl_r;
            state_r <= S_CHECK;
          end else if (found_r) begin
            num_r    <= 65'(de) * 65'(mag);
            den_r    <= dx;
            neg_r    <= dy[32];
            div_go_r <= 1'b1;
            state_r  <= S_DIV;
          end else begin
            stat_r  <= stir_pkg::STAT_RANGE;
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          // Step toward y1, truncated toward zero
          if (div_done) begin
            rate_r  <= neg_r ? 32'(by0_r - div_q[31:0]) : 32'(by0_r + div_q[31:0]);
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rate_r[31]) begin
            stat_r  <= stir_pkg::STAT_NEG_RATE;
            state_r <= S_DONE;
          end else begin
            acc_r    <= {{(PW - 32){1'b0}}, rate_r};
            mi_r     <= '0;
            mul_go_r <= 1'b1;
            state_r  <= S_PROD;
          end
        end
        S_PROD: begin
          if (mul_done) begin
            acc_r <= mul_p;
            if (mi_r == 2'd2) begin
              state_r <= S_SHIFT;
            end else begin
              mi_r     <= mi_r + 2'd1;
              mul_go_r <= 1'b1;
            end
          end
        end
        S_SHIFT: begin
          // Drop the fraction and saturate
          prog_r  <= (|shifted[PW-1:63]) ? stir_pkg::PROG_MAX : shifted[62:0];
          stat_r  <= stir_pkg::STAT_OK;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= (stat_r == stir_pkg::STAT_OK) ? prog_r : '0;
            out_stat_r  <= stat_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign out_tuser  = out_stat_r;

  `STIR_ASSERT_IMP(a_ring_home, state_r == S_IDLE, k_r == '0, "table ring not home at idle")
  `STIR_ASSERT_IMP(a_err_zero, out_tvalid && (out_tuser != stir_pkg::STAT_OK), out_tdata == '0, "nonzero progress on error")
  `STIR_ASSERT_IMP(a_bracket_order, found_r, bx0_r < bx1_r, "bracket energies out of order")
  `STIR_ASSERT_NXT(a_scan_len, (state_r == S_SCAN) && (k_r != KW'(TABLE_DEPTH - 1)), state_r == S_SCAN, "scan left early")

endmodule

### sv/stir_cell.sv
// One table cell: holds a breakpoint and passes it to its neighbor on rotate.
`timescale 1ns / 1ps
module stir_cell (
  input  logic            clk,
  input  logic            wr_en,
  input  stir_pkg::entry_t wr_d,
  input  logic            shift_en,
  input  stir_pkg::entry_t nb_d,
  output stir_pkg::entry_t q
);

  stir_pkg::entry_t q_r;

  // Load a breakpoint, or take the neighbor's entry while rotating
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r <= wr_d;
    end else if (shift_en) begin
      q_r <= nb_d;
    end
  end

  assign q = q_r;

endmodule

### sv/stir_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module stir_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [stir_pkg::DIV_NUM_W-1:0] num,
  input  logic [31:0]                    den,
  output logic                           done,
  output logic [stir_pkg::DIV_NUM_W-1:0] quo
);

  localparam int NW = stir_pkg::DIV_NUM_W;

  logic          busy_r;
  logic          done_r;
  logic [6:0]    cnt_r;
  logic [31:0]   den_r;
  logic [31:0]   rem_r;
  logic [NW-1:0] quo_r;
  logic [32:0]   trial;
  logic [33:0]   diff;

  // Bring down the next numerator bit and try the subtraction
  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        if (!diff[33]) begin
          rem_r <= diff[31:0];
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
        if (cnt_r == 7'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 7'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### sv/stir_mul.sv
// Limb-serial multiplier: wide accumulator times a 64-bit operand, 32x32 per cycle.
`timescale 1ns / 1ps
module stir_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [stir_pkg::PROD_W-1:0] a,
  input  logic [63:0]                 m,
  output logic                        done,
  output logic [stir_pkg::PROD_W-1:0] p
);

  localparam int PW = stir_pkg::PROD_W;

  logic          run_r;
  logic [2:0]    j_r;
  logic          c_r;
  logic [PW-1:0] a_r;
  logic [63:0]   m_r;
  logic [63:0]   pp_r;
  logic [2:0]    sh_r;
  logic          ppv_r;
  logic          last_r;
  logic          done_r;
  logic [PW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      ppv_r  <= 1'b0;
      last_r <= 1'b0;
      done_r <= 1'b0;
      j_r    <= '0;
      c_r    <= 1'b0;
    end else begin
      ppv_r  <= 1'b0;
      last_r <= 1'b0;
      done_r <= last_r;
      // Accumulate the registered partial product at its limb offset
      if (ppv_r) begin
        sum_r <= sum_r + ({{(PW - 64){1'b0}}, pp_r} << {sh_r, 5'd0});
      end
      if (start) begin
        run_r <= 1'b1;
        a_r   <= a;
        m_r   <= m;
        j_r   <= '0;
        c_r   <= 1'b0;
        sum_r <= '0;
      end else if (run_r) begin
        // Form one 32x32 partial product per cycle
        pp_r  <= 64'(a_r[{j_r, 5'd0} +: 32]) * 64'(m_r[{c_r, 5'd0} +: 32]);
        sh_r  <= j_r + {2'b00, c_r};
        ppv_r <= 1'b1;
        if (c_r) begin
          c_r <= 1'b0;
          if (j_r == 3'(stir_pkg::LIMBS - 1)) begin
            run_r  <= 1'b0;
            last_r <= 1'b1;
          end else begin
            j_r <= j_r + 3'd1;
          end
        end else begin
          c_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = sum_r;

endmodule
